// File: rtl/core/csvt_pkg.sv
// Shared types and constants for the CSV field tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package csvt_pkg;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] SEP_RESET = 8'd44;

   localparam logic FUNC_DATA = 1'b0;
   localparam logic FUNC_EOI  = 1'b1;

   typedef enum logic [1:0] {
      MODE_PLAIN      = 2'd0,
      MODE_QUOTED     = 2'd1,
      MODE_QUOTE_SEEN = 2'd2,
      MODE_CR_SEEN    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_DATA       = 3'd0,
      KIND_END_CELL   = 3'd1,
      KIND_END_LINE   = 3'd2,
      KIND_END_INPUT  = 3'd3,
      KIND_OPEN_QUOTE = 3'd4,
      KIND_BAD_EOL    = 3'd5
   } kind_type;

   typedef struct packed {
      logic       func;
      logic [7:0] byte_in;
   } req_item_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_out;
   } rsp_item_type;

   typedef struct packed {
      logic         has_result;
      rsp_item_type item;
   } scan_result_type;

endpackage

`default_nettype wire

// File: rtl/core/csv_field_tokenizer.sv
// An accepted item passes the input and output registers before its result is
// on rsp_valid. Throughput: one item per cycle unless rsp_stall holds a full
// output register. Items with no result (opening or closing quote, CR) still
// advance the scan mode. Reset (synchronous, active high) empties both stages,
// returns the scan mode to plain and the separator to comma (44).
`timescale 1ns / 1ps
`default_nettype none

module csv_field_tokenizer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_func,
   input  wire logic [7:0] req_byte_in,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_kind,
   output logic [7:0]      rsp_byte_out,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_separator
);

   csvt_pkg::req_item_type    req_item;
   csvt_pkg::req_item_type    stage_item;
   csvt_pkg::rsp_item_type    out_item;
   csvt_pkg::scan_result_type scan_res;
   logic                      stage_valid;
   logic                      out_valid;
   logic                      out_free;
   logic                      advance;
   logic                      req_take;

   assign req_item.func    = req_func;
   assign req_item.byte_in = req_byte_in;

   // Advance the held item when the output slot is free or draining
   assign out_free  = !out_valid || !rsp_stall;
   assign advance   = stage_valid && out_free;
   assign req_stall = reset || (stage_valid && !out_free);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = !reset;

   csvt_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (req_take),
      .advance (advance),
      .item_in (req_item),
      .valid   (stage_valid),
      .item    (stage_item)
   );

   csvt_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .item     (stage_item),
      .sep_we   (csr_valid && csr_ready),
      .sep_data (csr_separator),
      .result   (scan_res)
   );

   csvt_out_reg u_out_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (advance && scan_res.has_result),
      .stall   (rsp_stall),
      .item_in (scan_res.item),
      .valid   (out_valid),
      .item    (out_item)
   );

   assign rsp_valid    = out_valid;
   assign rsp_kind     = out_item.kind;
   assign rsp_byte_out = out_item.byte_out;

endmodule

`default_nettype wire

// File: rtl/core/csvt_in_reg.sv
// Input register stage: holds one accepted item until the scanner takes it.
`timescale 1ns / 1ps
`default_nettype none

module csvt_in_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire logic                  advance,
   input  wire csvt_pkg::req_item_type item_in,
   output logic                       valid,
   output csvt_pkg::req_item_type     item
);

   logic                   valid_ff;
   logic                   valid_in;
   csvt_pkg::req_item_type item_ff;

   // Keep the slot full on a load, empty it when the scanner consumes it
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

`default_nettype wire

// File: rtl/core/csvt_scan.sv
// Scan state machine: quote/CR tracking, separator register and result decode.
`timescale 1ns / 1ps
`default_nettype none

module csvt_scan (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire csvt_pkg::req_item_type item,
   input  wire logic                   sep_we,
   input  wire logic [7:0]             sep_data,
   output csvt_pkg::scan_result_type   result
);

   csvt_pkg::mode_type mode_ff;
   csvt_pkg::mode_type mode_in;
   logic [7:0]         sep_ff;

   logic is_quote;
   logic is_cr;
   logic is_lf;
   logic is_sep;

   assign is_quote = (item.byte_in == csvt_pkg::CH_QUOTE);
   assign is_cr    = (item.byte_in == csvt_pkg::CH_CR);
   assign is_lf    = (item.byte_in == csvt_pkg::CH_LF);
   assign is_sep   = (item.byte_in == sep_ff);

   // Separator register
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= csvt_pkg::SEP_RESET;
      end else if (sep_we) begin
         sep_ff <= sep_data;
      end
   end

   // Next scan mode
   always_comb begin
      mode_in = mode_ff;
      if (step) begin
         if (item.func == csvt_pkg::FUNC_EOI) begin
            mode_in = csvt_pkg::MODE_PLAIN;
         end else begin
            unique case (mode_ff)
               csvt_pkg::MODE_QUOTED: begin
                  if (is_quote) mode_in = csvt_pkg::MODE_QUOTE_SEEN;
               end
               csvt_pkg::MODE_QUOTE_SEEN: begin
                  // doubled quote stays quoted; CR waits for LF; anything else reads as plain
                  if (is_quote) mode_in = csvt_pkg::MODE_QUOTED;
                  else if (is_cr) mode_in = csvt_pkg::MODE_CR_SEEN;
                  else mode_in = csvt_pkg::MODE_PLAIN;
               end
               csvt_pkg::MODE_CR_SEEN: begin
                  mode_in = csvt_pkg::MODE_PLAIN;
               end
               csvt_pkg::MODE_PLAIN: begin
                  if (is_quote) mode_in = csvt_pkg::MODE_QUOTED;
                  else if (is_cr) mode_in = csvt_pkg::MODE_CR_SEEN;
               end
               default: mode_in = csvt_pkg::MODE_PLAIN;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= csvt_pkg::MODE_PLAIN;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Result for the current item
   always_comb begin
      result.has_result    = 1'b0;
      result.item.kind     = csvt_pkg::KIND_DATA;
      result.item.byte_out = 8'd0;
      if (item.func == csvt_pkg::FUNC_EOI) begin
         result.has_result = 1'b1;
         if (mode_ff == csvt_pkg::MODE_QUOTED) begin
            result.item.kind = csvt_pkg::KIND_OPEN_QUOTE;
         end else if (mode_ff == csvt_pkg::MODE_CR_SEEN) begin
            result.item.kind = csvt_pkg::KIND_BAD_EOL;
         end else begin
            result.item.kind = csvt_pkg::KIND_END_INPUT;
         end
      end else begin
         unique case (mode_ff)
            csvt_pkg::MODE_QUOTED: begin
               if (!is_quote) begin
                  result.has_result    = 1'b1;
                  result.item.byte_out = item.byte_in;
               end
            end
            csvt_pkg::MODE_CR_SEEN: begin
               result.has_result = 1'b1;
               result.item.kind  = is_lf ? csvt_pkg::KIND_END_LINE
                                         : csvt_pkg::KIND_BAD_EOL;
            end
            csvt_pkg::MODE_QUOTE_SEEN, csvt_pkg::MODE_PLAIN: begin
               // quote after a closing quote is a literal; in plain it opens
               priority if (is_quote) begin
                  if (mode_ff == csvt_pkg::MODE_QUOTE_SEEN) begin
                     result.has_result    = 1'b1;
                     result.item.byte_out = csvt_pkg::CH_QUOTE;
                  end
               end else if (is_cr) begin
                  result.has_result = 1'b0;
               end else if (is_lf) begin
                  result.has_result = 1'b1;
                  result.item.kind  = csvt_pkg::KIND_END_LINE;
               end else if (is_sep) begin
                  result.has_result = 1'b1;
                  result.item.kind  = csvt_pkg::KIND_END_CELL;
               end else begin
                  result.has_result    = 1'b1;
                  result.item.byte_out = item.byte_in;
               end
            end
            default: result.has_result = 1'b0;
         endcase
      end
   end

`ifndef SYNTHESIS
   // A byte after CR always reports something
   a_cr_reports: assert property (@(posedge clock) disable iff (reset)
      step && mode_ff == csvt_pkg::MODE_CR_SEEN |-> result.has_result)
      else $error("no result for byte after CR");

   // End of input returns to plain mode
   a_eoi_plain: assert property (@(posedge clock) disable iff (reset)
      step && item.func == csvt_pkg::FUNC_EOI |=> mode_ff == csvt_pkg::MODE_PLAIN)
      else $error("mode not plain after end of input");

   // Only data results carry a character
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      step && result.has_result && result.item.kind != csvt_pkg::KIND_DATA
      |-> result.item.byte_out == 8'd0)
      else $error("nonzero byte on control result");

   // Opening a quote gives no result and enters quoted mode
   a_open_quote: assert property (@(posedge clock) disable iff (reset)
      step && item.func == csvt_pkg::FUNC_DATA && is_quote
      && mode_ff == csvt_pkg::MODE_PLAIN
      |-> !result.has_result ##1 mode_ff == csvt_pkg::MODE_QUOTED)
      else $error("quote open mishandled");
`endif

endmodule

`default_nettype wire

// File: rtl/core/csvt_out_reg.sv
// Output register stage: holds one result item until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module csvt_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire logic                  stall,
   input  wire csvt_pkg::rsp_item_type item_in,
   output logic                       valid,
   output csvt_pkg::rsp_item_type     item
);

   logic                   valid_ff;
   logic                   valid_in;
   csvt_pkg::rsp_item_type item_ff;

   // Hold while stalled, replace on load, else drain
   assign valid_in = load | (valid_ff & stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the CSV field tokenizer with a built-in scan predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 6;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic       req_func      = csvt_pkg::FUNC_DATA;
   logic [7:0] req_byte_in   = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_byte_out;
   logic       csr_valid     = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_separator = csvt_pkg::SEP_RESET;

   // Predictor state: scan mode and the separator the block holds
   csvt_pkg::mode_type     scan_state = csvt_pkg::MODE_PLAIN;
   logic [7:0]             sep_value  = csvt_pkg::SEP_RESET;
   csvt_pkg::rsp_item_type expected_tokens[$];

   int mismatches    = 0;
   int cycle_count   = 0;
   bit idle_enabled  = 1'b1;
   bit hold_off_req  = 1'b0;

   csv_field_tokenizer u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_byte_in  (req_byte_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_byte_out (rsp_byte_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_separator(csr_separator)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("csv_field_tokenizer verification failed");
            $finish;
         end
      end
   end

   // Mostly short gaps, a few long ones, zero half the time
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic void queue_token(input csvt_pkg::kind_type kind,
                                       input logic [7:0] ch);
      csvt_pkg::rsp_item_type t;
      t.kind     = kind;
      t.byte_out = ch;
      expected_tokens.push_back(t);
   endfunction

   // Handle a non-quote byte outside quotes
   function automatic void scan_outside(input logic [7:0] ch);
      scan_state = csvt_pkg::MODE_PLAIN;
      if (ch == csvt_pkg::CH_CR)
         scan_state = csvt_pkg::MODE_CR_SEEN;
      else if (ch == csvt_pkg::CH_LF)
         queue_token(csvt_pkg::KIND_END_LINE, 8'h00);
      else if (ch == sep_value)
         queue_token(csvt_pkg::KIND_END_CELL, 8'h00);
      else
         queue_token(csvt_pkg::KIND_DATA, ch);
   endfunction

   // Advance the scan state by one accepted item and queue its token, if any
   function automatic void scan_item(input logic func, input logic [7:0] ch);
      csvt_pkg::mode_type prev;
      prev = scan_state;
      if (func == csvt_pkg::FUNC_EOI) begin
         scan_state = csvt_pkg::MODE_PLAIN;
         case (prev)
            csvt_pkg::MODE_QUOTED:  queue_token(csvt_pkg::KIND_OPEN_QUOTE, 8'h00);
            csvt_pkg::MODE_CR_SEEN: queue_token(csvt_pkg::KIND_BAD_EOL, 8'h00);
            default:                queue_token(csvt_pkg::KIND_END_INPUT, 8'h00);
         endcase
         return;
      end
      case (prev)
         csvt_pkg::MODE_QUOTED: begin
            if (ch == csvt_pkg::CH_QUOTE)
               scan_state = csvt_pkg::MODE_QUOTE_SEEN;
            else
               queue_token(csvt_pkg::KIND_DATA, ch);
         end
         csvt_pkg::MODE_QUOTE_SEEN: begin
            if (ch == csvt_pkg::CH_QUOTE) begin
               scan_state = csvt_pkg::MODE_QUOTED;
               queue_token(csvt_pkg::KIND_DATA, csvt_pkg::CH_QUOTE);
            end else begin
               scan_outside(ch);
            end
         end
         csvt_pkg::MODE_CR_SEEN: begin
            scan_state = csvt_pkg::MODE_PLAIN;
            if (ch == csvt_pkg::CH_LF)
               queue_token(csvt_pkg::KIND_END_LINE, 8'h00);
            else
               queue_token(csvt_pkg::KIND_BAD_EOL, 8'h00);
         end
         default: begin
            if (ch == csvt_pkg::CH_QUOTE)
               scan_state = csvt_pkg::MODE_QUOTED;
            else
               scan_outside(ch);
         end
      endcase
   endfunction

   // Offer one item, hold it while stalled, predict once accepted
   task automatic send_item(input logic func, input logic [7:0] ch);
      int gap;
      gap = idle_enabled ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_byte_in <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scan_item(func, ch);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(csvt_pkg::FUNC_DATA, s[i]);
   endtask

   task automatic send_eoi();
      send_item(csvt_pkg::FUNC_EOI, 8'($urandom_range(0, 255)));
   endtask

   // Stop offering and wait until every token has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_separator(input logic [7:0] value);
      drain_results();
      csr_separator <= value;
      csr_valid     <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sep_value = value;
   endtask

   // CSV-like text with random content, plus some raw noise bytes and end-of-input items
   task automatic send_random_text(input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            send_eoi();
         end else if (r < 18) begin
            send_item(csvt_pkg::FUNC_DATA, csvt_pkg::CH_QUOTE);
         end else if (r < 33) begin
            send_item(csvt_pkg::FUNC_DATA, sep_value);
         end else if (r < 41) begin
            send_item(csvt_pkg::FUNC_DATA, csvt_pkg::CH_CR);
            if ($urandom_range(0, 4) != 0) send_item(csvt_pkg::FUNC_DATA, csvt_pkg::CH_LF);
         end else if (r < 48) begin
            send_item(csvt_pkg::FUNC_DATA, csvt_pkg::CH_LF);
         end else if (r < 88) begin
            send_item(csvt_pkg::FUNC_DATA, 8'($urandom_range(8'h20, 8'h7E)));
         end else begin
            send_item(csvt_pkg::FUNC_DATA, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Receiver: random stalls, a long hold-off on request, or none at all
   initial begin : rsp_flow
      int span;
      forever begin
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (!idle_enabled) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 35);
            span = pick_gap() + 1;
            repeat (span) @(posedge clock);
         end
      end
   end

   // Compare each accepted token with the oldest prediction
   always @(posedge clock) begin : check_tokens
      csvt_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            $error("unexpected token: kind %0d byte_out 0x%02h", rsp_kind, rsp_byte_out);
            mismatches++;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, rsp_kind);
               mismatches++;
            end
            if (rsp_byte_out !== want.byte_out) begin
               $error("byte_out: expected 0x%02h, actual 0x%02h", want.byte_out,
                      rsp_byte_out);
               mismatches++;
            end
         end
      end
   end

   // Extremes, every token kind, quoting, CR handling and end of input per mode
   task automatic test_directed();
      send_item(csvt_pkg::FUNC_DATA, 8'h00);
      send_item(csvt_pkg::FUNC_DATA, 8'hFF);
      send_text(",\n\",\"\"\015\",\015\n\015q\"\"\n");
      send_eoi();
      send_text("\"");
      send_eoi();
      send_text("\015");
      send_eoi();
      send_text("\"\"");
      send_eoi();
      drain_results();
   endtask

   // Separator colliding with quote, CR or LF, each sent before and after a quote byte
   task automatic test_separator_collision();
      logic [7:0] picks[3];
      picks = '{csvt_pkg::CH_QUOTE, csvt_pkg::CH_CR, csvt_pkg::CH_LF};
      foreach (picks[i]) begin
         write_separator(picks[i]);
         send_item(csvt_pkg::FUNC_DATA, picks[i]);
         send_item(csvt_pkg::FUNC_DATA, csvt_pkg::CH_QUOTE);
         send_item(csvt_pkg::FUNC_DATA, picks[i]);
         send_item(csvt_pkg::FUNC_DATA, csvt_pkg::CH_QUOTE);
      end
      drain_results();
   endtask

   task automatic test_random_separators();
      logic [7:0] picks[6];
      picks = '{csvt_pkg::SEP_RESET, 8'h00, 8'hFF, csvt_pkg::CH_QUOTE, 8'h3B,
                8'($urandom_range(0, 255))};
      foreach (picks[i]) begin
         write_separator(picks[i]);
         send_random_text(200);
      end
      drain_results();
   endtask

   // Hold the receiver off long enough to fill the block and stall its input
   task automatic test_backpressure();
      idle_enabled = 1'b0;
      hold_off_req = 1'b1;
      send_random_text(60);
      wait (!hold_off_req);
      idle_enabled = 1'b1;
      drain_results();
   endtask

   // Pause the sender until every token is back, several times
   task automatic test_sender_pause();
      repeat (5) begin
         send_random_text(20);
         drain_results();
      end
   endtask

   task automatic test_streaming();
      idle_enabled = 1'b0;
      send_random_text(150);
      idle_enabled = 1'b1;
      drain_results();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_separator_collision();
      test_random_separators();
      test_backpressure();
      test_sender_pause();
      test_streaming();
      drain_results();
      if (mismatches == 0)
         $display("csv_field_tokenizer verification clean");
      else
         $display("csv_field_tokenizer verification failed");
      $finish;
   end

endmodule
